[design/aubb_pkg.sv]
// ----------------------------------------------------------------------------
// aubb_pkg
// Shared widths, types and helpers for the alpha union bounding box core.
// ----------------------------------------------------------------------------
package aubb_pkg;

   localparam int AUBB_MAX_DIM    = 4096;
   localparam int ALPHA_W         = 8;
   localparam int COORD_W         = 12;
   localparam int SIZE_W          = 13;
   localparam int REQ_DATA_W      = 64;
   localparam int RSP_DATA_W      = 48;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int QDEPTH          = 4;
   localparam int QPTR_W          = 2;
   localparam int QCNT_W          = 3;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ALPHA_THRESHOLD = 2'd0;

   // one classified pixel, as it waits between front and back
   typedef struct packed {
      logic               opaque;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [SIZE_W-1:0]  frame_width;
      logic [SIZE_W-1:0]  frame_height;
      logic               frame_end;
      logic               set_end;
   } pix_entry_type;

   // box snapshot handed to the output stage on a set end
   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [SIZE_W-1:0]  base_width;
      logic [SIZE_W-1:0]  base_height;
   } box_snap_type;

   function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                  input int max_dim);
      logic [16:0] lim;
      lim = 17'(max_dim);
      if ({4'b0, v} > lim) begin
         return lim[SIZE_W-1:0];
      end
      return v;
   endfunction

   // base - edge - 1, floored at zero and capped at max_dim - 1
   function automatic logic [COORD_W-1:0] margin_after(input logic [SIZE_W-1:0] base,
                                                       input logic [COORD_W-1:0] edge_pos,
                                                       input int max_dim);
      logic [SIZE_W-1:0] e1;
      logic [SIZE_W-1:0] m;
      logic [16:0]       lim;
      e1  = {1'b0, edge_pos} + 13'd1;
      m   = base - e1;
      lim = 17'(max_dim - 1);
      if (base <= e1) begin
         return '0;
      end
      if ({4'b0, m} > lim) begin
         return lim[COORD_W-1:0];
      end
      return m[COORD_W-1:0];
   endfunction

endpackage

[design/aubb_front.sv]
// ----------------------------------------------------------------------------
// aubb_front
// Register port, request intake and opacity classification.
// ----------------------------------------------------------------------------
module aubb_front
   import aubb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output pix_entry_type         q_entry
);

   logic [ALPHA_W-1:0] threshold_ff;
   logic [ALPHA_W-1:0] threshold_in;
   logic               csr_wr;
   logic [ALPHA_W-1:0] alpha;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_wr && csr_paddr == ADDR_ALPHA_THRESHOLD) begin
         threshold_in = csr_pwdata[ALPHA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_ALPHA_THRESHOLD) begin
         csr_prdata = {{(CSR_DATA_W-ALPHA_W){1'b0}}, threshold_ff};
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   assign alpha                = req_tdata[7:0];
   assign q_entry.opaque       = alpha > threshold_ff;
   assign q_entry.col          = req_tdata[19:8];
   assign q_entry.row          = req_tdata[31:20];
   assign q_entry.frame_width  = req_tdata[44:32];
   assign q_entry.frame_height = req_tdata[57:45];
   assign q_entry.frame_end    = req_tlast;
   assign q_entry.set_end      = req_tuser;

endmodule

[design/aubb_queue.sv]
// ----------------------------------------------------------------------------
// aubb_queue
// Small FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module aubb_queue
   import aubb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pix_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output pix_entry_type head_entry
);

   pix_entry_type      slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == QCNT_W'(QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/aubb_back.sv]
// ----------------------------------------------------------------------------
// aubb_back
// Frame and union box tracking, base size capture and margin output stage.
// ----------------------------------------------------------------------------
module aubb_back
   import aubb_pkg::*;
#(
   parameter int MAX_DIM = AUBB_MAX_DIM
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  pix_entry_type         q_entry,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic [COORD_W-1:0] frame_left_ff, frame_top_ff, frame_right_ff, frame_bottom_ff;
   logic [COORD_W-1:0] frame_left_in, frame_top_in, frame_right_in, frame_bottom_in;
   logic               frame_hit_ff, frame_hit_in;
   logic [COORD_W-1:0] union_left_ff, union_top_ff, union_right_ff, union_bottom_ff;
   logic [COORD_W-1:0] union_left_in, union_top_in, union_right_in, union_bottom_in;
   logic               union_hit_ff, union_hit_in;
   logic [SIZE_W-1:0]  base_width_ff, base_width_in;
   logic [SIZE_W-1:0]  base_height_ff, base_height_in;

   logic [COORD_W-1:0] fl, ft, fr, fb, ul, ut, ur, ub;
   logic               fh, uh;
   logic [SIZE_W-1:0]  bw, bh;

   box_snap_type       snap_ff, snap_in;
   logic               snap_valid_ff, snap_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic               out_found_ff, out_found_in;
   logic               out_adv, snap_ready;

   assign out_adv    = !out_valid_ff || rsp_tready;
   assign snap_ready = !snap_valid_ff || out_adv;
   assign q_pop      = q_valid && (!q_entry.set_end || snap_ready);

   always_comb begin
      bw = base_width_ff;
      bh = base_height_ff;
      if (base_width_ff == '0 && q_entry.frame_width != '0) begin
         bw = sat_size(q_entry.frame_width, MAX_DIM);
         bh = sat_size(q_entry.frame_height, MAX_DIM);
      end
      fl = frame_left_ff;
      ft = frame_top_ff;
      fr = frame_right_ff;
      fb = frame_bottom_ff;
      fh = frame_hit_ff;
      if (q_entry.opaque) begin
         if (q_entry.col < frame_left_ff) fl = q_entry.col;
         if (q_entry.row < frame_top_ff)  ft = q_entry.row;
         if (!frame_hit_ff || q_entry.col > frame_right_ff)  fr = q_entry.col;
         if (!frame_hit_ff || q_entry.row > frame_bottom_ff) fb = q_entry.row;
         fh = 1'b1;
      end
      ul = union_left_ff;
      ut = union_top_ff;
      ur = union_right_ff;
      ub = union_bottom_ff;
      uh = union_hit_ff;
      if (q_entry.frame_end || q_entry.set_end) begin
         if (fh) begin
            if (fl < union_left_ff) ul = fl;
            if (ft < union_top_ff)  ut = ft;
            if (!union_hit_ff || fr > union_right_ff)  ur = fr;
            if (!union_hit_ff || fb > union_bottom_ff) ub = fb;
            uh = 1'b1;
         end
         fl = '1;
         ft = '1;
         fr = '0;
         fb = '0;
         fh = 1'b0;
      end

      snap_in.found       = uh && bw != '0;
      snap_in.top         = ut;
      snap_in.left        = ul;
      snap_in.right       = ur;
      snap_in.bottom      = ub;
      snap_in.base_width  = bw;
      snap_in.base_height = bh;

      frame_left_in   = fl;
      frame_top_in    = ft;
      frame_right_in  = fr;
      frame_bottom_in = fb;
      frame_hit_in    = fh;
      union_left_in   = ul;
      union_top_in    = ut;
      union_right_in  = ur;
      union_bottom_in = ub;
      union_hit_in    = uh;
      base_width_in   = bw;
      base_height_in  = bh;
      if (q_entry.set_end) begin
         union_left_in   = '1;
         union_top_in    = '1;
         union_right_in  = '0;
         union_bottom_in = '0;
         union_hit_in    = 1'b0;
         base_width_in   = '0;
         base_height_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_left_ff   <= '1;
         frame_top_ff    <= '1;
         frame_right_ff  <= '0;
         frame_bottom_ff <= '0;
         frame_hit_ff    <= 1'b0;
         union_left_ff   <= '1;
         union_top_ff    <= '1;
         union_right_ff  <= '0;
         union_bottom_ff <= '0;
         union_hit_ff    <= 1'b0;
         base_width_ff   <= '0;
         base_height_ff  <= '0;
      end else if (q_pop) begin
         frame_left_ff   <= frame_left_in;
         frame_top_ff    <= frame_top_in;
         frame_right_ff  <= frame_right_in;
         frame_bottom_ff <= frame_bottom_in;
         frame_hit_ff    <= frame_hit_in;
         union_left_ff   <= union_left_in;
         union_top_ff    <= union_top_in;
         union_right_ff  <= union_right_in;
         union_bottom_ff <= union_bottom_in;
         union_hit_ff    <= union_hit_in;
         base_width_ff   <= base_width_in;
         base_height_ff  <= base_height_in;
      end
   end

   // snapshot stage, then margins are worked out into the output register
   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (q_pop && q_entry.set_end) begin
         snap_valid_in = 1'b1;
      end else if (out_adv) begin
         snap_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_found_in = out_found_ff;
      if (out_adv) begin
         out_valid_in = snap_valid_ff;
         out_found_in = snap_ff.found;
         out_data_in  = '0;
         if (snap_ff.found) begin
            out_data_in = {margin_after(snap_ff.base_height, snap_ff.bottom, MAX_DIM),
                           margin_after(snap_ff.base_width, snap_ff.right, MAX_DIM),
                           snap_ff.left,
                           snap_ff.top};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_entry.set_end) begin
         snap_ff <= snap_in;
      end
      out_data_ff  <= out_data_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_found_ff;

endmodule

[design/alpha_union_bounding_box_core.sv]
// A set-end request passes through the queue, the snapshot register and the output register before its result shows.
// Throughput: one request per cycle unless the queue is full; the box registers in the back end update on each pop.
// A four-entry queue decouples intake from the back end; results leave via an output register.
// Reset (synchronous, active high) clears the threshold, boxes, base size, queue and
// all valid flags; no clearing pass, the block accepts requests in the cycle after reset.
// ----------------------------------------------------------------------------
// alpha_union_bounding_box_core
// Auto-crop margins over a set of frames from their alpha bytes.
// ----------------------------------------------------------------------------
module alpha_union_bounding_box_core
   import aubb_pkg::*;
#(
   parameter int MAX_DIM = AUBB_MAX_DIM
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] alpha, [19:8] col, [31:20] row, [44:32] frame_width,
   // [57:45] frame_height, [63:58] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,   // frame_end
   input  logic                  req_tuser,   // [0] set_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [11:0] margin_top, [23:12] margin_left, [35:24] margin_right,
   // [47:36] margin_bottom
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser    // [0] found
);

   logic          q_full;
   logic          q_push;
   pix_entry_type q_push_entry;
   logic          q_pop;
   logic          q_valid;
   pix_entry_type q_head;

   aubb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_push_entry)
   );

   aubb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   aubb_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[design/aubb_checker.sv]
// ----------------------------------------------------------------------------
// aubb_checker
// Port-level checks on the alpha union bounding box core.
// ----------------------------------------------------------------------------
module aubb_checker
   import aubb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_pready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // nothing found means zero margins
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("margins set without a hit");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind alpha_union_bounding_box_core aubb_checker u_aubb_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_pready (csr_pready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for alpha_union_bounding_box_core: streams pixel
// requests for sets of frames, predicts the crop margins of each set in step
// with accepted requests and compares every result against the prediction.
// ----------------------------------------------------------------------------
module testbench;
   import aubb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_LIMIT = AUBB_MAX_DIM;
   localparam logic [COORD_W-1:0] COORD_ONES = '1;

   typedef struct {
      logic [ALPHA_W-1:0] alpha;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [SIZE_W-1:0]  fw;
      logic [SIZE_W-1:0]  fh;
      logic               fend;
      logic               send;
   } pixel_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic               found;
   } crop_result_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   alpha_union_bounding_box_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   pixel_req_type   pixel_queue[$];
   crop_result_type margin_queue[$];
   pixel_req_type   offered;
   int              pushed_total   = 0;
   int              accepted_total = 0;
   int              error_count    = 0;
   int              mismatch_count = 0;
   logic            calm           = 1'b0;
   logic            hold_go        = 1'b0;
   int              hold_left      = 0;

   // predictor state
   logic [ALPHA_W-1:0] opaque_level;
   logic [COORD_W-1:0] frm_left, frm_top, frm_right, frm_bottom;
   logic               frm_hit;
   logic [COORD_W-1:0] uni_left, uni_top, uni_right, uni_bottom;
   logic               uni_hit;
   logic [SIZE_W-1:0]  base_w, base_h;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

   function automatic void clear_frame_box();
      frm_left   = COORD_ONES;
      frm_top    = COORD_ONES;
      frm_right  = '0;
      frm_bottom = '0;
      frm_hit    = 1'b0;
   endfunction

   function automatic void clear_crop_set();
      clear_frame_box();
      uni_left   = COORD_ONES;
      uni_top    = COORD_ONES;
      uni_right  = '0;
      uni_bottom = '0;
      uni_hit    = 1'b0;
      base_w     = '0;
      base_h     = '0;
   endfunction

   function automatic logic [COORD_W-1:0] crop_margin(input int base, input int edge_pos);
      int m;
      if (base <= edge_pos + 1) begin
         return '0;
      end
      m = base - edge_pos - 1;
      if (m > DIM_LIMIT - 1) begin
         m = DIM_LIMIT - 1;
      end
      return m[COORD_W-1:0];
   endfunction

   // advances the box tracking by one pixel; returns 1 when a set closes
   function automatic bit crop_track(input pixel_req_type px, output crop_result_type res);
      res = '0;
      if (base_w == 0 && px.fw != 0) begin
         base_w = (px.fw > DIM_LIMIT) ? SIZE_W'(DIM_LIMIT) : px.fw;
         base_h = (px.fh > DIM_LIMIT) ? SIZE_W'(DIM_LIMIT) : px.fh;
      end
      if (px.alpha > opaque_level) begin
         if (px.col < frm_left) frm_left = px.col;
         if (px.row < frm_top) frm_top = px.row;
         if (!frm_hit || px.col > frm_right) frm_right = px.col;
         if (!frm_hit || px.row > frm_bottom) frm_bottom = px.row;
         frm_hit = 1'b1;
      end
      // set end closes the open frame as well
      if (px.fend || px.send) begin
         if (frm_hit) begin
            if (frm_left < uni_left) uni_left = frm_left;
            if (frm_top < uni_top) uni_top = frm_top;
            if (!uni_hit || frm_right > uni_right) uni_right = frm_right;
            if (!uni_hit || frm_bottom > uni_bottom) uni_bottom = frm_bottom;
            uni_hit = 1'b1;
         end
         clear_frame_box();
      end
      if (!px.send) begin
         return 1'b0;
      end
      if (uni_hit && base_w != 0) begin
         res.top    = uni_top;
         res.left   = uni_left;
         res.right  = crop_margin(int'(base_w), int'(uni_right));
         res.bottom = crop_margin(int'(base_h), int'(uni_bottom));
         res.found  = 1'b1;
      end
      clear_crop_set();
      return 1'b1;
   endfunction

   // ---- request generation ----
   function automatic void push_pixel(input int a, input int c, input int r, input int w,
                                      input int h, input bit fe, input bit se);
      pixel_req_type px;
      px.alpha = a[ALPHA_W-1:0];
      px.col   = c[COORD_W-1:0];
      px.row   = r[COORD_W-1:0];
      px.fw    = w[SIZE_W-1:0];
      px.fh    = h[SIZE_W-1:0];
      px.fend  = fe;
      px.send  = se;
      pixel_queue = {pixel_queue, px};
      pushed_total++;
   endfunction

   // alpha values mostly at or below the threshold, plus the threshold, one above it and the extremes
   function automatic int pick_alpha();
      int lvl;
      lvl = int'(opaque_level);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom_range(lvl, 0);
         5:             return lvl;
         6:             return (lvl + 1) & 8'hFF;
         7:             return 255;
         8:             return 0;
         default:       return $urandom_range(255);
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(7))
         0:       return 0;
         1:       return 8191;
         2:       return DIM_LIMIT;
         3:       return DIM_LIMIT + 1;
         default: return $urandom_range(8191, 1);
      endcase
   endfunction

   function automatic void push_raster_frame(input int w, input int h, input bit fe_last,
                                             input bit se_last);
      bit last;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            last = (r == h - 1) && (c == w - 1);
            push_pixel(pick_alpha(), c, r, w, h, last && fe_last, last && se_last);
         end
      end
   endfunction

   // few pixels at random coordinates in a frame of any size
   function automatic void push_sparse_frame(input bit fe_last, input bit se_last);
      int w, h, n;
      w = pick_size();
      h = pick_size();
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
         push_pixel(pick_alpha(), $urandom_range(4095), $urandom_range(4095), w, h,
                    (i == n - 1) && fe_last, (i == n - 1) && se_last);
      end
   endfunction

   function automatic void push_set();
      int  n, w, h;
      bit  last, fe;
      n = $urandom_range(3, 1);
      for (int f = 0; f < n; f++) begin
         last = (f == n - 1);
         fe   = !last || ($urandom_range(3) != 0);
         if ($urandom_range(4) == 0) begin
            push_sparse_frame(fe, last);
         end else begin
            if ($urandom_range(9) == 0) begin
               w = $urandom_range(40, 1);
               h = 1;
            end else begin
               w = $urandom_range(6, 1);
               h = $urandom_range(5, 1);
            end
            push_raster_frame(w, h, fe, last);
         end
      end
   endfunction

   function automatic void push_random_phase(input int count);
      int start;
      start = pushed_total;
      while (pushed_total - start < count) begin
         if ($urandom_range(99) < 8) begin
            push_pixel($urandom_range(255), $urandom_range(4095), $urandom_range(4095),
                       $urandom_range(8191), $urandom_range(8191),
                       $urandom_range(3) == 0, $urandom_range(3) == 0);
         end else begin
            push_set();
         end
      end
      push_set();
   endfunction

   task automatic write_threshold(input logic [ALPHA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_ALPHA_THRESHOLD;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      opaque_level = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // all requests taken, all results back, then let the pipe settle
   task automatic drain();
      while (accepted_total != pushed_total || margin_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // ---- request driver ----
   always @(posedge clock) begin
      crop_result_type res;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_total++;
            if (crop_track(offered, res)) begin
               margin_queue = {margin_queue, res};
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
               offered = pixel_queue.pop_front();
               req_tdata  <= {6'b0, offered.fh, offered.fw, offered.row, offered.col,
                              offered.alpha};
               req_tlast  <= offered.fend;
               req_tuser  <= offered.send;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---- result monitor ----
   always @(posedge clock) begin
      crop_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.top    = rsp_tdata[11:0];
            got.left   = rsp_tdata[23:12];
            got.right  = rsp_tdata[35:24];
            got.bottom = rsp_tdata[47:36];
            got.found  = rsp_tuser;
            if (margin_queue.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected margins t=%0d l=%0d r=%0d b=%0d found=%0b",
                           got.top, got.left, got.right, got.bottom, got.found);
               end
            end else begin
               want = margin_queue.pop_front();
               if (got.top !== want.top || got.left !== want.left ||
                   got.right !== want.right || got.bottom !== want.bottom ||
                   got.found !== want.found) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("margin mismatch: expected t=%0d l=%0d r=%0d b=%0d found=%0b",
                              want.top, want.left, want.right, want.bottom, want.found);
                     $display("                 got      t=%0d l=%0d r=%0d b=%0d found=%0b",
                              got.top, got.left, got.right, got.bottom, got.found);
                  end
               end
            end
         end
         if (hold_go) begin
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 19);
         end
      end
   end

   // ---- sequence ----
   initial begin
      opaque_level = '0;
      clear_crop_set();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed requests at threshold zero
      write_threshold(8'd0);
      push_pixel(0, 7, 7, 8, 8, 1, 1);                 // nothing opaque
      push_pixel(255, 0, 0, 1, 1, 1, 1);               // single opaque pixel
      push_pixel(255, 5, 5, 0, 7, 0, 0);               // zero width: base never captured
      push_pixel(0, 0, 0, 0, 0, 1, 1);
      push_pixel(255, 4095, 4095, 8191, 8191, 1, 1);   // oversize base saturates
      push_pixel(200, 0, 0, 8191, 4097, 1, 1);
      push_pixel(0, 0, 0, 2, 2, 0, 0);                 // later frame larger than base
      push_pixel(0, 1, 1, 2, 2, 1, 0);
      push_pixel(255, 100, 50, 200, 100, 1, 1);
      push_pixel(9, 3000, 20, 4, 4, 1, 1);             // coordinates beyond frame
      push_pixel(1, 2, 3, 10, 10, 0, 0);               // set end without frame end
      push_pixel(0, 0, 0, 10, 10, 0, 1);
      push_pixel(255, 4095, 0, 4096, 4096, 0, 0);
      push_pixel(128, 0, 4095, 4096, 4096, 1, 1);
      push_pixel(1, 3, 1, 4096, 1, 1, 0);              // two frames merged
      push_pixel(1, 1, 2, 3, 3, 1, 1);
      drain();

      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1:       write_threshold(8'd255);
            3:       write_threshold(8'd1);
            4:       write_threshold(8'd254);
            5:       write_threshold(8'd128);
            default: write_threshold(ALPHA_W'($urandom_range(255)));
         endcase
         calm <= (phase == 4) || (phase == 5);
         if (phase == 5) begin
            // receiver held off while single-pixel sets pile up
            for (int i = 0; i < 48; i++) begin
               push_pixel(pick_alpha(), $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(8191), $urandom_range(8191),
                          $urandom_range(1), 1);
            end
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         push_random_phase(270);
         drain();
      end
      calm <= 1'b0;

      if (error_count == 0 && margin_queue.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

[files.f]
design/aubb_pkg.sv
design/aubb_front.sv
design/aubb_queue.sv
design/aubb_back.sv
design/alpha_union_bounding_box_core.sv
design/aubb_checker.sv
tb/sv/testbench.sv
